[sv/ray_box_slab_test_core_macros.svh]
// assertion macros for the ray box slab test core
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rbst assertion failed");
`define RBST_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rbst assertion failed");
`else
`define RBST_ASSERT(lbl, prop)
`define RBST_ASSERT_NR(lbl, prop)
`endif
`endif

[sv/rbst_pkg.sv]
// shared constants and types of the ray box slab test core
package rbst_pkg;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DIR_EPSILON = 0;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned NUM_W       = VAL_W + 1;
  localparam int unsigned SCL_W       = NUM_W + FRAC_BITS;
  localparam int unsigned QUO_W       = VAL_W;
  localparam int unsigned WIDE_W      = 2 * VAL_W;
  localparam int unsigned BITS_PER    = 2;
  localparam int unsigned DIV_STEPS   = QUO_W / BITS_PER;
  localparam int unsigned LANE_LAT    = DIV_STEPS + 1;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned DIST_W      = VAL_W - 1;

  localparam logic signed [VAL_W-1:0] T_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] T_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic                vld;
    logic [NUM_AXES-1:0] par;
    logic                pmiss;
  } side_t;
endpackage

[sv/rbst_div_lane.sv]
// pipelined fixed-point divider lane, two quotient bits per stage
module rbst_div_lane (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [rbst_pkg::NUM_W-1:0]              num_mag_i,
  input  logic [rbst_pkg::VAL_W-1:0]              den_mag_i,
  input  logic                                    neg_i,
  output logic signed [rbst_pkg::VAL_W-1:0]       quo_o
);
  localparam int unsigned NS = rbst_pkg::DIV_STEPS;

  logic [rbst_pkg::SCL_W-1:0] rem_q [0:NS];
  logic [rbst_pkg::QUO_W-1:0] quo_q [0:NS];
  logic [rbst_pkg::VAL_W-1:0] den_q [0:NS];
  logic                       neg_q [0:NS];
  logic                       ovf_q [0:NS];

  logic [rbst_pkg::SCL_W-1:0] rem_d [1:NS];
  logic [rbst_pkg::QUO_W-1:0] quo_d [1:NS];
  logic                       ovf_d;
  logic [rbst_pkg::WIDE_W-1:0] scl_w;

  // magnitude of at least 2^32 always saturates
  assign scl_w = rbst_pkg::WIDE_W'({num_mag_i, {rbst_pkg::FRAC_BITS{1'b0}}});
  assign ovf_d = scl_w >= {den_mag_i, {rbst_pkg::VAL_W{1'b0}}};

  for (genvar s = 1; s <= NS; s++) begin : g_step
    always_comb begin
      logic [rbst_pkg::WIDE_W-1:0] r;
      logic [rbst_pkg::WIDE_W-1:0] dsh;
      logic [rbst_pkg::QUO_W-1:0]  q;
      r = rbst_pkg::WIDE_W'(rem_q[s-1]);
      q = quo_q[s-1];
      for (int b = 0; b < rbst_pkg::BITS_PER; b++) begin
        dsh = rbst_pkg::WIDE_W'(den_q[s-1])
              << (rbst_pkg::QUO_W - 1 - (s - 1) * rbst_pkg::BITS_PER - b);
        q = {q[rbst_pkg::QUO_W-2:0], 1'b0};
        if (r >= dsh) begin
          r    = r - dsh;
          q[0] = 1'b1;
        end
      end
      rem_d[s] = r[rbst_pkg::SCL_W-1:0];
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {num_mag_i, {rbst_pkg::FRAC_BITS{1'b0}}};
      quo_q[0] <= '0;
      den_q[0] <= den_mag_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf_d;
      for (int s = 1; s <= NS; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  // sign and saturation
  always_comb begin
    logic [rbst_pkg::QUO_W:0] qx;
    qx = {1'b0, quo_q[NS]};
    if (neg_q[NS]) begin
      if (ovf_q[NS] || qx > {2'b01, {(rbst_pkg::QUO_W-1){1'b0}}}) begin
        quo_o = rbst_pkg::T_MIN;
      end else begin
        quo_o = rbst_pkg::VAL_W'(-qx);
      end
    end else begin
      if (ovf_q[NS] || qx > {2'b00, {(rbst_pkg::QUO_W-1){1'b1}}}) begin
        quo_o = rbst_pkg::T_MAX;
      end else begin
        quo_o = rbst_pkg::VAL_W'(qx);
      end
    end
  end
endmodule

[sv/ray_box_slab_test_core.sv]
// top level of the ray box slab test core
// Pipelined ray versus axis-aligned box slab test in signed Q16.16. One
// ray/box transaction is accepted per cycle unless the output is stalled,
// and passes 21 register stages: a front stage forms corner-minus-origin
// and magnitudes, six divider lanes of 17 stages each (one overflow check,
// then two quotient bits per stage) give the saturated slab distances, and
// three back stages order each pair, reduce the interval and form hit and
// entry distance.
// An axis with |dir| at or below the epsilon is handled as parallel and
// misses only when the origin lies outside that slab. A stalled output
// freezes the whole pipeline; in_stall_o is high exactly then.
module ray_box_slab_test_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [30:0] entry_distance_o
);
  `include "ray_box_slab_test_core_macros.svh"

  localparam int unsigned NA = rbst_pkg::NUM_AXES;
  localparam int unsigned LL = rbst_pkg::LANE_LAT;

  logic en;

  logic signed [rbst_pkg::VAL_W-1:0] org [0:NA-1];
  logic signed [rbst_pkg::VAL_W-1:0] dir [0:NA-1];
  logic signed [rbst_pkg::VAL_W-1:0] bmin [0:NA-1];
  logic signed [rbst_pkg::VAL_W-1:0] bmax [0:NA-1];

  // front stage registers
  logic [rbst_pkg::NUM_W-1:0] nlo_q [0:NA-1];
  logic [rbst_pkg::NUM_W-1:0] nhi_q [0:NA-1];
  logic                       neglo_q [0:NA-1];
  logic                       neghi_q [0:NA-1];
  logic [rbst_pkg::VAL_W-1:0] dmag_q [0:NA-1];

  rbst_pkg::side_t side_q [0:LL];
  rbst_pkg::side_t side_d;

  logic signed [rbst_pkg::VAL_W-1:0] tlo_w [0:NA-1];
  logic signed [rbst_pkg::VAL_W-1:0] thi_w [0:NA-1];

  // back stages
  logic signed [rbst_pkg::VAL_W-1:0] t0_q [0:NA-1];
  logic signed [rbst_pkg::VAL_W-1:0] t1_q [0:NA-1];
  logic                              ord_vld_q, ord_miss_q;
  logic signed [rbst_pkg::VAL_W-1:0] tmin_q, tmax_q;
  logic                              red_vld_q, red_miss_q;
  logic                              out_vld_q, hit_q;
  logic [rbst_pkg::DIST_W-1:0]       dist_q;

  // whole pipeline advances unless the result register is held
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  assign org  = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir  = '{dir_x_i, dir_y_i, dir_z_i};
  assign bmin = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign bmax = '{box_max_x_i, box_max_y_i, box_max_z_i};

  // parallel test and slab containment for the front stage
  always_comb begin
    side_d.vld   = in_valid_i;
    side_d.pmiss = 1'b0;
    for (int a = 0; a < NA; a++) begin
      logic [rbst_pkg::VAL_W-1:0] dm;
      dm = dir[a][rbst_pkg::VAL_W-1] ? rbst_pkg::VAL_W'(-dir[a]) : dir[a];
      side_d.par[a] = dm <= rbst_pkg::VAL_W'(rbst_pkg::DIR_EPSILON);
      if (side_d.par[a] && (org[a] < bmin[a] || org[a] > bmax[a])) begin
        side_d.pmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        logic signed [rbst_pkg::NUM_W-1:0] nl, nh;
        nl = rbst_pkg::NUM_W'(bmin[a]) - rbst_pkg::NUM_W'(org[a]);
        nh = rbst_pkg::NUM_W'(bmax[a]) - rbst_pkg::NUM_W'(org[a]);
        nlo_q[a]   <= nl[rbst_pkg::NUM_W-1] ? rbst_pkg::NUM_W'(-nl) : nl;
        nhi_q[a]   <= nh[rbst_pkg::NUM_W-1] ? rbst_pkg::NUM_W'(-nh) : nh;
        neglo_q[a] <= nl[rbst_pkg::NUM_W-1] ^ dir[a][rbst_pkg::VAL_W-1];
        neghi_q[a] <= nh[rbst_pkg::NUM_W-1] ^ dir[a][rbst_pkg::VAL_W-1];
        dmag_q[a]  <= dir[a][rbst_pkg::VAL_W-1] ? rbst_pkg::VAL_W'(-dir[a]) : dir[a];
      end
    end
  end

  // flags travel beside the divider lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LL; s++) side_q[s] <= '0;
    end else if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s <= LL; s++) side_q[s] <= side_q[s-1];
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbst_div_lane u_div_lo (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (nlo_q[a]),
      .den_mag_i (dmag_q[a]),
      .neg_i     (neglo_q[a]),
      .quo_o     (tlo_w[a])
    );
    rbst_div_lane u_div_hi (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (nhi_q[a]),
      .den_mag_i (dmag_q[a]),
      .neg_i     (neghi_q[a]),
      .quo_o     (thi_w[a])
    );
  end

  // order each pair; parallel axes take the interval identities
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        if (side_q[LL].par[a]) begin
          t0_q[a] <= '0;
          t1_q[a] <= rbst_pkg::T_MAX;
        end else if (tlo_w[a] > thi_w[a]) begin
          t0_q[a] <= thi_w[a];
          t1_q[a] <= tlo_w[a];
        end else begin
          t0_q[a] <= tlo_w[a];
          t1_q[a] <= thi_w[a];
        end
      end
      ord_miss_q <= side_q[LL].pmiss;
    end
  end

  // narrow the interval starting from zero and the largest value
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [rbst_pkg::VAL_W-1:0] lo, hi;
      lo = '0;
      hi = rbst_pkg::T_MAX;
      for (int a = 0; a < NA; a++) begin
        if (t0_q[a] > lo) lo = t0_q[a];
        if (t1_q[a] < hi) hi = t1_q[a];
      end
      tmin_q     <= lo;
      tmax_q     <= hi;
      red_miss_q <= ord_miss_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= !red_miss_q && (tmin_q <= tmax_q);
      dist_q <= (!red_miss_q && (tmin_q <= tmax_q)) ?
                tmin_q[rbst_pkg::DIST_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_vld_q <= 1'b0;
      red_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      ord_vld_q <= side_q[LL].vld;
      red_vld_q <= ord_vld_q;
      out_vld_q <= red_vld_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign hit_o            = hit_q;
  assign entry_distance_o = dist_q;

  // a miss always reports zero distance
  `RBST_ASSERT(a_miss_zero, out_valid_o && !hit_o |-> entry_distance_o == '0)
  // the input side is held exactly when a finished result waits
  `RBST_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i))
  // a held result keeps its transaction until taken
  `RBST_ASSERT(a_hold_result, out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
endmodule

[tb/tb_top.sv]
// self-checking testbench for the ray box slab test core
`timescale 1ns / 1ps
module tb_top;

  // one ray/box pair as driven on the ports
  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
  } ray_box_t;

  // one hit/distance pair as seen on the ports
  typedef struct {
    logic        hit;
    logic [30:0] entry_dist;
  } slab_hit_t;

  // predicts the slab test and holds pending hit results in order
  class slab_scoreboard;
    slab_hit_t pending_hits[$];
    int        errors;

    function longint div_sat(longint num, longint den);
      longint q;
      q = (num * (longint'(1) << rbst_pkg::FRAC_BITS)) / den;
      if (q > longint'(rbst_pkg::T_MAX)) q = longint'(rbst_pkg::T_MAX);
      if (q < longint'(rbst_pkg::T_MIN)) q = longint'(rbst_pkg::T_MIN);
      return q;
    endfunction

    function slab_hit_t slab_test(ray_box_t rb);
      slab_hit_t r;
      longint    t_near, t_far, o, d, lo, hi, t0, t1, sw, mag;
      bit        hit;
      t_near = 0;
      t_far  = longint'(rbst_pkg::T_MAX);
      hit    = 1'b1;
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
        o   = rb.org[a];
        d   = rb.dir[a];
        lo  = rb.bmin[a];
        hi  = rb.bmax[a];
        mag = (d < 0) ? -d : d;
        if (mag <= longint'(rbst_pkg::DIR_EPSILON)) begin
          // parallel axis: only the slab containment matters
          if (o < lo || o > hi) begin
            hit = 1'b0;
            break;
          end
          continue;
        end
        t0 = div_sat(lo - o, d);
        t1 = div_sat(hi - o, d);
        if (t0 > t1) begin
          sw = t0;
          t0 = t1;
          t1 = sw;
        end
        if (t0 > t_near) t_near = t0;
        if (t1 < t_far) t_far = t1;
        if (t_near > t_far) begin
          hit = 1'b0;
          break;
        end
      end
      r.hit        = hit;
      r.entry_dist = hit ? t_near[30:0] : '0;
      return r;
    endfunction

    function void note_ray(ray_box_t rb);
      pending_hits.push_back(slab_test(rb));
    endfunction

    function void check_hit(logic hit, logic [30:0] entry_dist);
      slab_hit_t exp_r;
      if (pending_hits.size() == 0) begin
        $error("unexpected result hit=%0b entry_distance=%0h", hit, entry_dist);
        errors++;
        return;
      end
      exp_r = pending_hits.pop_front();
      if (hit !== exp_r.hit) begin
        $error("hit: expected %0b actual %0b", exp_r.hit, hit);
        errors++;
      end
      if (entry_dist !== exp_r.entry_dist) begin
        $error("entry_distance: expected %0h actual %0h", exp_r.entry_dist, entry_dist);
        errors++;
      end
    endfunction
  endclass

  localparam int NUM_RANDOM = 374;
  localparam int WATCHDOG   = 20000;
  localparam int DRAIN_CYC  = rbst_pkg::LANE_LAT + 20;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, hit_o;
  logic [30:0] entry_distance_o;
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];

  slab_scoreboard sb = new();
  bit  quiet_phase;   // no idling near the end
  bit  hold_request;  // ask the receiver for a long hold-off
  bit  stim_done;
  int  idle_cycles = 0;

  ray_box_slab_test_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .origin_x_i(org_q[0]), .origin_y_i(org_q[1]), .origin_z_i(org_q[2]),
    .dir_x_i(dir_q[0]), .dir_y_i(dir_q[1]), .dir_z_i(dir_q[2]),
    .box_min_x_i(bmin_q[0]), .box_min_y_i(bmin_q[1]), .box_min_z_i(bmin_q[2]),
    .box_max_x_i(bmax_q[0]), .box_max_y_i(bmax_q[1]), .box_max_z_i(bmax_q[2]),
    .out_valid_o, .out_stall_i, .hit_o, .entry_distance_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random 32-bit value, biased toward extremes and small magnitudes
  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // direction lane: sometimes exactly zero to hit the parallel path
  function automatic logic signed [31:0] pick_dir();
    if ($urandom_range(5) == 0) return '0;
    return pick_val();
  endfunction

  // mostly well-formed boxes with randomly picked corners, some inverted
  function automatic ray_box_t random_ray();
    ray_box_t rb;
    logic signed [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      rb.org[i] = pick_val();
      rb.dir[i] = pick_dir();
      a = pick_val();
      b = pick_val();
      if ($urandom_range(7) != 0 && a > b) begin
        rb.bmin[i] = b;
        rb.bmax[i] = a;
      end else begin
        rb.bmin[i] = a;
        rb.bmax[i] = b;
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int lx, int ly, int lz, int hx, int hy, int hz);
    ray_box_t rb;
    rb.org  = '{ox, oy, oz};
    rb.dir  = '{dx, dy, dz};
    rb.bmin = '{lx, ly, lz};
    rb.bmax = '{hx, hy, hz};
    return rb;
  endfunction

  // random idle burst on the sending side
  task automatic send_gap();
    if (!quiet_phase && $urandom_range(5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // offer one transaction and hold it until accepted
  task automatic send_ray(ray_box_t rb);
    send_gap();
    in_valid_i <= 1'b1;
    org_q  <= rb.org;
    dir_q  <= rb.dir;
    bmin_q <= rb.bmin;
    bmax_q <= rb.bmax;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_ray(rb);
  endtask

  localparam int ONE = 32'sh0001_0000;
  localparam int MX  = 32'sh7fff_ffff;
  localparam int MN  = 32'sh8000_0000;

  initial begin
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    rst_ni       = 1'b0;
    org_q  = '{default: '0};
    dir_q  = '{default: '0};
    bmin_q = '{default: '0};
    bmax_q = '{default: '0};
    quiet_phase  = 1'b0;
    hold_request = 1'b0;
    stim_done    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain hit, origin inside, misses, parallel axes, far box,
    // inverted boxes, negative directions, full-scale extremes
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 3*ONE));
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_ray(make_ray(0, 0, 0, ONE, 0, 0, 2*ONE, 5*ONE, -ONE, 3*ONE, 6*ONE, ONE));
    send_ray(make_ray(0, 0, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE));
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE, 2*ONE, 2*ONE, 2*ONE));
    send_ray(make_ray(0, 0, 0, -ONE, -ONE, -ONE, -3*ONE, -3*ONE, -3*ONE, -2*ONE, -2*ONE,
                      -2*ONE));
    send_ray(make_ray(0, 0, 0, 1, 1, 1, MX - 5, MX - 5, MX - 5, MX, MX, MX));
    send_ray(make_ray(MN, MN, MN, 1, 1, 1, MX - 1, MX - 1, MX - 1, MX, MX, MX));
    send_ray(make_ray(MX, MX, MX, MN, MN, MN, MN, MN, MN, MX, MX, MX));
    send_ray(make_ray(MX, MN, 0, MX, MN, -1, MN, MN, MN, MX, MX, MX));
    send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, -ONE, 2*ONE, -ONE, ONE, 3*ONE, ONE));
    send_ray(make_ray(5*ONE, 0, 0, -ONE, 0, 0, ONE, 0, 0, 2*ONE, 0, 0));
    send_ray(make_ray(ONE, 0, 0, 0, ONE, 0, ONE, 0, -ONE, ONE, 0, ONE));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, MN, MN, MN, -1, -1, -1));

    // long receiver hold-off while the sender keeps offering
    hold_request = 1'b1;
    for (int n = 0; n < 60; n++) send_ray(random_ray());

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 60) quiet_phase = 1'b1;
      send_ray(random_ray());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (120) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_hit(hit_o, entry_distance_o);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fork
      begin
        wait (stim_done);
        while (sb.pending_hits.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYC) @(posedge clk_i);
      end
      begin
        @(posedge rst_ni);
        wait (idle_cycles >= WATCHDOG);
        sb.errors++;
      end
    join_any
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/rbst_pkg.sv
sv/rbst_div_lane.sv
sv/ray_box_slab_test_core.sv
tb/tb_top.sv
